[sv/rgbc_pkg.sv]
`timescale 1ns / 1ps
package rgbc_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int WidthW   = 11;
  localparam int HeightW  = 16;
  localparam int CoefW    = 48;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 48;
  localparam int ProdW    = 25;
  localparam int MagW     = 24;
  localparam int MagicW   = 25;
  localparam int DivShift = 28;

  localparam logic [WidthW-1:0] MaxWidthV = WidthW'(MaxWidth);
  localparam logic [MagicW-1:0] DivMagic  = 25'd26843546;

  localparam logic [CfgIdxW-1:0] RegWidth     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefAbove = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefSame  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefBelow = 3'd4;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef logic [31:0] pix_t;
  typedef logic [8:0][31:0] win_t;
  typedef logic [CoefW-1:0] coef_t;

  typedef struct packed {
    logic [8:0]       mask;
    logic             last;
    logic [7:0]       alpha;
    logic [8:0][23:0] rgb;
  } job_t;

  function automatic logic [8:0] make_mask(logic [2:0] rows, logic [2:0] cols);
    logic [8:0] m;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        m[dr*3+dc] = rows[dr] & cols[dc];
      end
    end
    return m;
  endfunction

  function automatic job_t make_job(win_t px, logic [8:0] mask, logic last);
    job_t j;
    j.mask  = mask;
    j.last  = last;
    j.alpha = px[4][31:24];
    for (int i = 0; i < 9; i++) begin
      j.rgb[i] = px[i][23:0];
    end
    return j;
  endfunction

endpackage

[sv/rgbc_conv.sv]
`timescale 1ns / 1ps
module rgbc_conv (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  rgbc_pkg::job_t  job,
  input  rgbc_pkg::coef_t coef_above,
  input  rgbc_pkg::coef_t coef_same,
  input  rgbc_pkg::coef_t coef_below,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha,
  output logic            frame_last
);
  import rgbc_pkg::*;

  logic en1, en2, en3;
  logic v1, v2;
  coef_t cf [3];
  logic signed [15:0] kk [9];
  logic signed [ProdW-1:0] prod [9][3];
  logic signed [ProdW-1:0] p1_prod [9][3];
  logic       p1_last, p2_last;
  logic [7:0] p1_alpha, p2_alpha;
  logic [7:0] q8 [9][3];
  logic [7:0] p2_q [9][3];
  logic [7:0] sum [3];

  assign en3 = !out_valid || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign job_ready = en1;

  assign cf[0] = coef_above;
  assign cf[1] = coef_same;
  assign cf[2] = coef_below;

  always_comb begin
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        kk[dr*3+dc] = $signed(cf[dc][16*dr +: 16]);
      end
    end
    for (int i = 0; i < 9; i++) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (job.mask[i]) begin
          prod[i][ch] = $signed({1'b0, job.rgb[i][8*ch +: 8]}) * kk[i];
        end else begin
          prod[i][ch] = '0;
        end
      end
    end
  end

  always_comb begin
    logic [ProdW-1:0] mag;
    logic [MagW+MagicW-1:0] qf;
    logic [7:0] q;
    for (int i = 0; i < 9; i++) begin
      for (int ch = 0; ch < 3; ch++) begin
        mag = p1_prod[i][ch][ProdW-1] ? ProdW'(-p1_prod[i][ch]) : p1_prod[i][ch];
        qf = mag[MagW-1:0] * DivMagic;
        q = qf[DivShift +: 8];
        q8[i][ch] = p1_prod[i][ch][ProdW-1] ? 8'(-q) : q;
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int i = 0; i < 9; i++) begin
        sum[ch] = sum[ch] + p2_q[i][ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= job_valid;
      if (en2) v2 <= v1;
      if (en3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_prod  <= prod;
      p1_last  <= job.last;
      p1_alpha <= job.alpha;
    end
    if (en2) begin
      p2_q     <= q8;
      p2_last  <= p1_last;
      p2_alpha <= p1_alpha;
    end
    if (en3) begin
      out_red    <= sum[0];
      out_green  <= sum[1];
      out_blue   <= sum[2];
      out_alpha  <= p2_alpha;
      frame_last <= p2_last;
    end
  end

endmodule

[sv/rgb_convolution_3x3.sv]
`timescale 1ns / 1ps
// Streaming 3x3 RGB convolution with two line memories (1024 x 32 bits each, one per row
// parity), read the cycle a pixel is accepted and written in the same cycle. One pixel
// transaction is accepted per clock unless the window stage stalls. A pixel that ends
// a row, from the second row on, yields two results and holds the window stage until
// the second is loaded. Results trail the input by one row; after the last row, send
// one drain transaction (command 1) per column to release it. Pixels after a full frame
// and drains before it are accepted and dropped.
module rgb_convolution_3x3 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [rgbc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rgbc_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           command,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  input  logic [7:0]                     in_alpha,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic                           frame_last
);
  import rgbc_pkg::*;

  logic [WidthW-1:0]  image_width;
  logic [HeightW-1:0] image_height;
  coef_t              coef_above, coef_same, coef_below;

  logic [WidthW-1:0]  w_eff, w_m1, c_ext;
  logic [HeightW-1:0] h_eff;
  logic [ColW-1:0]    in_column, col_plus1;
  logic [HeightW-1:0] in_row;

  logic accept, pix_ok, drain_ok, row_end, drain_last;
  logic cm2, cm1, c0, cp1;
  logic [8:0] mask_a, mask_b, mask_d;
  pix_t pixel;

  pix_t mem_even [MaxWidth];
  pix_t mem_odd  [MaxWidth];
  pix_t rd_a0, rd_a1, rd_b0, rd_b1, dprev0, dprev1;

  logic       s1_valid, s1_drain, s1_j1, s1_j2, s1_last, s1_par, s1_go;
  pix_t       s1_pix;
  logic [8:0] s1_mask1, s1_mask2, pend_mask;
  logic       second_pend;

  win_t win, nwin, dpx, tmp;
  pix_t row_p, row_np, b_p, b_np, prev_p, prev_np;

  logic j_valid, j_free, jload_first, jload_second, conv_ready;
  job_t j_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= MaxWidthV;
      image_height <= HeightW'(1);
      coef_above   <= '0;
      coef_same    <= CoefW'(655360);
      coef_below   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        RegWidth:     image_width  <= cfg_data[WidthW-1:0];
        RegHeight:    image_height <= cfg_data[HeightW-1:0];
        RegCoefAbove: coef_above   <= cfg_data[CoefW-1:0];
        RegCoefSame:  coef_same    <= cfg_data[CoefW-1:0];
        RegCoefBelow: coef_below   <= cfg_data[CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WidthW'(1);
    end else if (image_width > MaxWidthV) begin
      w_eff = MaxWidthV;
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? HeightW'(1) : image_height;
  end

  assign w_m1      = w_eff - WidthW'(1);
  assign c_ext     = {1'b0, in_column};
  assign col_plus1 = in_column + ColW'(1);
  assign pixel     = {in_alpha, in_blue, in_green, in_red};
  assign accept    = in_valid && in_ready;
  assign pix_ok    = (command == CMD_PIXEL) && (in_row < h_eff);
  assign drain_ok  = (command == CMD_DRAIN) && (in_row >= h_eff);
  assign row_end   = c_ext >= w_m1;
  assign drain_last = row_end;

  assign cm2 = (in_column >= ColW'(2)) && ((c_ext - WidthW'(2)) < w_eff);
  assign cm1 = (in_column != '0) && ((c_ext - WidthW'(1)) < w_eff);
  assign c0  = c_ext < w_eff;
  assign cp1 = (c_ext + WidthW'(1)) < w_eff;

  assign mask_a = make_mask({1'b1, 1'b1, in_row >= HeightW'(2)}, {c0, cm1, cm2});
  assign mask_b = make_mask({1'b1, 1'b1, in_row >= HeightW'(2)}, {cp1, c0, cm1});
  assign mask_d = make_mask({1'b0, 1'b1, h_eff >= HeightW'(2)}, {cp1, c0, cm1});

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (accept && pix_ok) begin
      if (row_end) begin
        in_column <= '0;
        in_row    <= in_row + HeightW'(1);
      end else begin
        in_column <= col_plus1;
      end
    end else if (accept && drain_ok) begin
      if (drain_last) begin
        in_column <= '0;
        in_row    <= '0;
      end else begin
        in_column <= col_plus1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a0 <= mem_even[in_column];
      rd_b0 <= mem_even[col_plus1];
    end
    if (accept && pix_ok && !in_row[0]) begin
      mem_even[in_column] <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a1 <= mem_odd[in_column];
      rd_b1 <= mem_odd[col_plus1];
    end
    if (accept && pix_ok && in_row[0]) begin
      mem_odd[in_column] <= pixel;
    end
  end

  assign in_ready = !s1_valid || s1_go;
  assign s1_go = s1_valid && !second_pend && (!s1_j1 || j_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept && (pix_ok || drain_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && accept) begin
      s1_drain <= drain_ok;
      s1_pix   <= pixel;
      if (drain_ok) begin
        s1_j1    <= 1'b1;
        s1_j2    <= 1'b0;
        s1_last  <= drain_last;
        s1_par   <= h_eff[0];
        s1_mask1 <= mask_d;
      end else begin
        s1_j1    <= (in_row != '0) && (in_column != '0);
        s1_j2    <= (in_row != '0) && row_end;
        s1_last  <= 1'b0;
        s1_par   <= in_row[0];
        s1_mask1 <= mask_a;
      end
      s1_mask2 <= mask_b;
    end
  end

  always_comb begin
    row_p   = s1_par ? rd_a1 : rd_a0;
    row_np  = s1_par ? rd_a0 : rd_a1;
    b_p     = s1_par ? rd_b1 : rd_b0;
    b_np    = s1_par ? rd_b0 : rd_b1;
    prev_p  = s1_par ? dprev1 : dprev0;
    prev_np = s1_par ? dprev0 : dprev1;
    for (int dr = 0; dr < 3; dr++) begin
      nwin[dr*3]   = win[dr*3+1];
      nwin[dr*3+1] = win[dr*3+2];
      tmp[dr*3]    = win[dr*3+1];
      tmp[dr*3+1]  = win[dr*3+2];
      tmp[dr*3+2]  = '0;
    end
    nwin[2] = row_p;
    nwin[5] = row_np;
    nwin[8] = s1_pix;
    dpx[0] = prev_p;
    dpx[1] = row_p;
    dpx[2] = b_p;
    dpx[3] = prev_np;
    dpx[4] = row_np;
    dpx[5] = b_np;
    dpx[6] = '0;
    dpx[7] = '0;
    dpx[8] = '0;
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_drain) begin
      win <= nwin;
    end
    if (s1_go && s1_drain) begin
      dprev0 <= rd_a0;
      dprev1 <= rd_a1;
    end
    if (s1_go) begin
      pend_mask <= s1_mask2;
    end
  end

  assign j_free       = !j_valid || conv_ready;
  assign jload_first  = s1_go && s1_j1;
  assign jload_second = second_pend && j_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_pend <= 1'b0;
      j_valid     <= 1'b0;
    end else begin
      if (s1_go && s1_j2) begin
        second_pend <= 1'b1;
      end else if (jload_second) begin
        second_pend <= 1'b0;
      end
      if (j_free) begin
        j_valid <= jload_first || jload_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (jload_first) begin
      j_reg <= make_job(s1_drain ? dpx : nwin, s1_mask1, s1_last);
    end else if (jload_second) begin
      j_reg <= make_job(tmp, pend_mask, 1'b0);
    end
  end

  rgbc_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (j_valid),
    .job_ready  (conv_ready),
    .job        (j_reg),
    .coef_above (coef_above),
    .coef_same  (coef_same),
    .coef_below (coef_below),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .frame_last (frame_last)
  );

  a_second_clears: assert property (@(posedge clk) disable iff (rst)
    second_pend && j_free |=> !second_pend)
    else $error("Pending second result was not issued.");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_pix) && $stable(s1_mask1))
    else $error("Window stage lost a stalled transaction.");

  a_job_holds: assert property (@(posedge clk) disable iff (rst)
    j_valid && !conv_ready |=> j_valid && $stable(j_reg))
    else $error("Job register changed while stalled.");

  a_no_double_load: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_j2 |=> second_pend && !s1_go)
    else $error("Window stage advanced over a pending second result.");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import rgbc_pkg::*;

  localparam int StallLimit = 3000;
  localparam int LongHold   = 400;

  typedef struct packed {
    cmd_t cmd;
    pix_t pix;
  } pixel_txn_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } conv_px_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                command = CMD_PIXEL;
  logic [7:0]          in_red = '0;
  logic [7:0]          in_green = '0;
  logic [7:0]          in_blue = '0;
  logic [7:0]          in_alpha = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_red;
  logic [7:0]          out_green;
  logic [7:0]          out_blue;
  logic [7:0]          out_alpha;
  logic                frame_last;

  rgb_convolution_3x3 i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .in_alpha   (in_alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .frame_last (frame_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow state of the convolution.
  pix_t              prev_rows[2*MaxWidth];
  pix_t              win_px[9];
  int                col_pos;
  int                row_pos;
  logic [WidthW-1:0] width_reg;
  logic [HeightW-1:0] height_reg;
  coef_t             coef_rows[3];

  conv_px_t   conv_q[$];
  pixel_txn_t pending[$];

  int  errors = 0;
  int  n_pixels = 0;
  int  n_drains = 0;
  int  n_results = 0;
  int  n_frames = 0;
  bit  in_fire = 0;
  bit  out_fire = 0;
  bit  no_idle = 0;
  bit  hold_req = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  stall_cnt = 0;

  function automatic int frame_w();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return int'(width_reg);
  endfunction

  function automatic int frame_h();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic int tap(int dr, int dc);
    logic [15:0] f;
    f = coef_rows[dc][16*dr +: 16];
    return int'($signed(f));
  endfunction

  function automatic pix_t row_rd(int row, int col);
    if (col < 0 || col >= MaxWidth) return '0;
    return prev_rows[(row & 1) * MaxWidth + col];
  endfunction

  function automatic void convolve(pix_t px[9], int orow, int ocol, bit last);
    int sum[3];
    int row;
    int col;
    int k;
    int v;
    conv_px_t e;
    sum = '{0, 0, 0};
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        row = orow - 1 + dr;
        col = ocol - 1 + dc;
        if (row < 0 || row >= frame_h() || col < 0 || col >= frame_w()) continue;
        k = tap(dr, dc);
        for (int ch = 0; ch < 3; ch++) begin
          v = int'(px[dr*3+dc][8*ch +: 8]);
          sum[ch] += (v * k) / 10;
        end
      end
    end
    e.red   = sum[0][7:0];
    e.green = sum[1][7:0];
    e.blue  = sum[2][7:0];
    e.alpha = px[4][31:24];
    e.last  = last;
    conv_q.push_back(e);
  endfunction

  function automatic void predict_conv(cmd_t cmd, pix_t pix);
    int w;
    int h;
    pix_t shifted[9];
    pix_t edge_px[9];
    bit last;
    w = frame_w();
    h = frame_h();
    if (cmd == CMD_PIXEL) begin
      if (row_pos >= h) return;
      n_pixels++;
      for (int dr = 0; dr < 3; dr++) begin
        win_px[dr*3]   = win_px[dr*3+1];
        win_px[dr*3+1] = win_px[dr*3+2];
      end
      win_px[2] = row_rd(row_pos, col_pos);
      win_px[5] = row_rd(row_pos + 1, col_pos);
      win_px[8] = pix;
      if (col_pos < MaxWidth) prev_rows[(row_pos & 1) * MaxWidth + col_pos] = pix;
      if (row_pos >= 1 && col_pos >= 1) convolve(win_px, row_pos - 1, col_pos - 1, 1'b0);
      if (col_pos >= w - 1) begin
        if (row_pos >= 1) begin
          for (int dr = 0; dr < 3; dr++) begin
            shifted[dr*3]   = win_px[dr*3+1];
            shifted[dr*3+1] = win_px[dr*3+2];
            shifted[dr*3+2] = '0;
          end
          convolve(shifted, row_pos - 1, col_pos, 1'b0);
        end
        col_pos = 0;
        row_pos = (row_pos + 1) & 16'hFFFF;
      end else begin
        col_pos++;
      end
    end else begin
      if (row_pos < h) return;
      n_drains++;
      for (int dc = 0; dc < 3; dc++) begin
        edge_px[dc]     = row_rd(h, col_pos - 1 + dc);
        edge_px[3 + dc] = row_rd(h + 1, col_pos - 1 + dc);
        edge_px[6 + dc] = '0;
      end
      last = (col_pos >= w - 1);
      convolve(edge_px, h - 1, col_pos, last);
      if (last) begin
        col_pos = 0;
        row_pos = 0;
        n_frames++;
      end else begin
        col_pos++;
      end
    end
  endfunction

  task automatic report(string field, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Acceptance, prediction, checking and the watchdog.
  always @(posedge clk) begin
    conv_px_t e;
    in_fire = !rst && in_valid && in_ready;
    out_fire = !rst && out_valid && out_ready;
    if (out_fire) begin
      n_results++;
      if (conv_q.size() == 0) begin
        report("unexpected result transaction", 1, 0);
      end else begin
        e = conv_q.pop_front();
        if (out_red !== e.red) report("out_red", out_red, e.red);
        if (out_green !== e.green) report("out_green", out_green, e.green);
        if (out_blue !== e.blue) report("out_blue", out_blue, e.blue);
        if (out_alpha !== e.alpha) report("out_alpha", out_alpha, e.alpha);
        if (frame_last !== e.last) report("frame_last", frame_last, e.last);
      end
    end
    if (in_fire) predict_conv(cmd_t'(command), {in_alpha, in_blue, in_green, in_red});
    if (!rst) begin
      stall_cnt = (in_fire || out_fire) ? 0 : stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("Timeout: no transaction for %0d cycles", StallLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Pixel driver.
  always @(negedge clk) begin
    pixel_txn_t t;
    if (!rst && !(in_valid && !in_fire)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        t = pending.pop_front();
        command  <= t.cmd;
        in_red   <= t.pix[7:0];
        in_green <= t.pix[15:8];
        in_blue  <= t.pix[23:16];
        in_alpha <= t.pix[31:24];
        in_valid <= 1'b1;
        tx_gap = no_idle ? 0 : $urandom_range(0, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_fire) rx_gap = no_idle ? 0 : $urandom_range(0, 19);
      if (hold_req) begin
        rx_gap = LongHold;
        hold_req = 0;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      RegWidth:     width_reg = data[WidthW-1:0];
      RegHeight:    height_reg = data[HeightW-1:0];
      RegCoefAbove: coef_rows[0] = data;
      RegCoefSame:  coef_rows[1] = data;
      RegCoefBelow: coef_rows[2] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || conv_q.size() != 0) @(posedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic setup(int w, int h, coef_t ca, coef_t cs, coef_t cb);
    wait_idle();
    cfg_write(RegWidth, CfgDataW'(w));
    cfg_write(RegHeight, CfgDataW'(h));
    cfg_write(RegCoefAbove, ca);
    cfg_write(RegCoefSame, cs);
    cfg_write(RegCoefBelow, cb);
  endtask

  function automatic void push_txn(cmd_t cmd, pix_t pix);
    pixel_txn_t t;
    t.cmd = cmd;
    t.pix = pix;
    pending.push_back(t);
  endfunction

  function automatic pix_t rand_pix();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic coef_t rand_coef();
    coef_t c;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0: c[16*k +: 16] = 16'h8000;
        1: c[16*k +: 16] = 16'h7FFF;
        2: c[16*k +: 16] = 16'h0000;
        3: c[16*k +: 16] = 16'($signed($urandom_range(0, 60)) - 30);
        default: c[16*k +: 16] = 16'($urandom);
      endcase
    end
    return c;
  endfunction

  // One full frame of random pixels and its drains, with a little ignored traffic mixed in when noise is set.
  function automatic void push_frame(int w, int h, bit noise);
    int ew;
    int eh;
    ew = (w == 0) ? 1 : (w > MaxWidth ? MaxWidth : w);
    eh = (h == 0) ? 1 : h;
    for (int i = 0; i < ew * eh; i++) begin
      if (noise && $urandom_range(0, 29) == 0) push_txn(CMD_DRAIN, rand_pix());
      push_txn(CMD_PIXEL, rand_pix());
    end
    if (noise && $urandom_range(0, 2) == 0) push_txn(CMD_PIXEL, rand_pix());
    for (int i = 0; i < ew; i++) push_txn(CMD_DRAIN, rand_pix());
  endfunction

  initial begin
    int sent;
    int w;
    int h;
    for (int i = 0; i < 2 * MaxWidth; i++) prev_rows[i] = '0;
    for (int i = 0; i < 9; i++) win_px[i] = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = 11'd1024;
    height_reg = 16'd1;
    coef_rows[0] = '0;
    coef_rows[1] = 48'd655360;
    coef_rows[2] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme pixels and coefficients, ignored drain and pixel.
    setup(3, 3, {16'h000A, 16'h8000, 16'h7FFF}, {16'h7FFF, 16'hFFF6, 16'h8000},
          {16'h8000, 16'h0001, 16'h7FFF});
    push_txn(CMD_DRAIN, '1);
    for (int i = 0; i < 9; i++) push_txn(CMD_PIXEL, (i % 2) ? 32'hFFFFFFFF : 32'h00000000);
    push_txn(CMD_PIXEL, 32'h12345678);
    for (int i = 0; i < 3; i++) push_txn(CMD_DRAIN, '0);
    setup(0, 0, '1, '1, '1);
    push_txn(CMD_PIXEL, 32'hFF00FF00);
    push_txn(CMD_DRAIN, '0);
    setup(2, 2, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0000_000A_FFFF);
    for (int i = 0; i < 4; i++) push_txn(CMD_PIXEL, i[0] ? 32'h00FF00FF : 32'hFF00FF00);
    for (int i = 0; i < 2; i++) push_txn(CMD_DRAIN, '0);

    // Tallest height setting, cut short once the column has been streamed.
    setup(1, 65535, rand_coef(), rand_coef(), rand_coef());
    for (int i = 0; i < 30; i++) push_txn(CMD_PIXEL, rand_pix());
    wait_idle();
    cfg_write(RegHeight, CfgDataW'(30));
    push_txn(CMD_DRAIN, '0);

    // Receiver stalls long enough for the block to back up its input.
    setup(40, 6, rand_coef(), rand_coef(), rand_coef());
    no_idle = 1;
    hold_req = 1;
    push_frame(40, 6, 0);

    sent = 0;
    while (sent < 1200) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 48);
      h = $urandom_range(0, 8);
      setup(w, h, rand_coef(), rand_coef(), rand_coef());
      no_idle = ($urandom_range(0, 3) == 0);
      push_frame(w, h, 1);
      sent += pending.size();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Covered %0d pixel and %0d drain transactions over %0d frames,",
             n_pixels, n_drains, n_frames);
    $display("with %0d convolved results checked and %0d mismatches.", n_results, errors);
    if (errors == 0 && conv_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
sv/rgbc_pkg.sv
sv/rgbc_conv.sv
sv/rgb_convolution_3x3.sv
dv/tb_top.sv
